>>> hw/rtl/nested_scope_profiler_macros.svh
// ----------------------------------------------------------------------------
// Nested scope profiler assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NESTED_SCOPE_PROFILER_MACROS_SVH
`define NESTED_SCOPE_PROFILER_MACROS_SVH

// Same-cycle implication.
`define NSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/nsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_pkg
// Opcodes, status codes, command kinds and fixed field widths.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int IDX_W    = 6;
  localparam int IDX_N    = 1 << IDX_W;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 64;
  localparam int CALLS_W  = 32;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // What the back end has to do with a request after stack handling.
  typedef enum logic [2:0] {
    K_BEGIN = 3'd0,
    K_END   = 3'd1,
    K_READ  = 3'd2,
    K_CLEAR = 3'd3,
    K_OVF   = 3'd4,
    K_UNF   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  has_parent;
  } cmd_ctl_t;

endpackage

>>> hw/rtl/nsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_in_if / nsp_out_if
// Valid/ready channels for profiler events and profiler results.
// ----------------------------------------------------------------------------
interface nsp_in_if #(parameter int TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [5:0]           scope_index;
  logic [TIME_BITS-1:0] timestamp;

  modport source (output valid, opcode, scope_index, timestamp, input ready);
  modport sink   (input valid, opcode, scope_index, timestamp, output ready);
endinterface

interface nsp_out_if #(parameter int TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [5:0]           result_scope;
  logic [TIME_BITS-1:0] elapsed;
  logic [63:0]          total_ticks;
  logic [31:0]          calls;
  logic [TIME_BITS-1:0] min_ticks;
  logic [TIME_BITS-1:0] max_ticks;
  logic [63:0]          nested_ticks;

  modport source (output valid, status, result_scope, elapsed, total_ticks, calls,
                  min_ticks, max_ticks, nested_ticks, input ready);
  modport sink   (input valid, status, result_scope, elapsed, total_ticks, calls,
                  min_ticks, max_ticks, nested_ticks, output ready);
endinterface

>>> hw/rtl/nsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/nsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_front
// Accepts requests, runs the scope stack and queues resolved commands.
// ----------------------------------------------------------------------------
module nsp_front #(
  parameter int NUM_SCOPES  = 64,
  parameter int STACK_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  nsp_in_if.sink                        in_ch,
  output logic                          cmd_valid,
  input  logic                          cmd_pop,
  output nsp_pkg::cmd_ctl_t             cmd_ctl,
  output logic [$clog2(NUM_SCOPES)-1:0] cmd_scope,
  output logic [$clog2(NUM_SCOPES)-1:0] cmd_parent,
  output logic [TIME_BITS-1:0]          cmd_time
);
  import nsp_pkg::*;

  localparam int SCOPE_W = $clog2(NUM_SCOPES);
  localparam int DEP_W   = $clog2(STACK_DEPTH + 1);

  typedef logic [SCOPE_W-1:0] mod_tbl_t [IDX_N];

  function automatic mod_tbl_t build_mod_tbl();
    mod_tbl_t t;
    for (int i = 0; i < IDX_N; i++) begin
      t[i] = SCOPE_W'(i % NUM_SCOPES);
    end
    return t;
  endfunction

  localparam mod_tbl_t MOD_TBL = build_mod_tbl();

  // stack: top of stack at slot 0, parent at slot 1
  logic [SCOPE_W-1:0] stk_r [STACK_DEPTH];
  logic [DEP_W-1:0]   dep_r, dep_nxt;
  logic               do_push, do_pop;

  // two-entry command queue
  cmd_ctl_t           q_ctl_r   [2];
  logic [SCOPE_W-1:0] q_scope_r [2];
  logic [SCOPE_W-1:0] q_par_r   [2];
  logic [TIME_BITS-1:0] q_time_r [2];
  logic       q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;

  logic               acc;
  logic [SCOPE_W-1:0] idx;
  cmd_ctl_t           n_ctl;
  logic [SCOPE_W-1:0] n_scope;
  logic [SCOPE_W-1:0] n_par;

  assign in_ch.ready = (q_cnt_r != 2'd2);
  assign acc         = in_ch.valid && in_ch.ready;
  assign idx         = MOD_TBL[in_ch.scope_index];

  always_comb begin
    n_ctl.kind       = K_READ;
    n_ctl.has_parent = 1'b0;
    n_scope          = idx;
    n_par            = stk_r[1];
    do_push          = 1'b0;
    do_pop           = 1'b0;
    dep_nxt          = dep_r;
    case (opcode_t'(in_ch.opcode))
      OP_BEGIN: begin
        if (dep_r == DEP_W'(STACK_DEPTH)) begin
          n_ctl.kind = K_OVF;
        end else begin
          n_ctl.kind = K_BEGIN;
          do_push    = acc;
          dep_nxt    = dep_r + 1'b1;
        end
      end
      OP_END: begin
        if (dep_r == '0) begin
          n_ctl.kind = K_UNF;
        end else begin
          n_ctl.kind       = K_END;
          n_ctl.has_parent = (dep_r > DEP_W'(1));
          n_scope          = stk_r[0];
          do_pop           = acc;
          dep_nxt          = dep_r - 1'b1;
        end
      end
      OP_READ:  n_ctl.kind = K_READ;
      OP_CLEAR: begin
        n_ctl.kind = K_CLEAR;
        dep_nxt    = '0;
      end
      default:  n_ctl.kind = K_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dep_r   <= '0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (acc) begin
        dep_r  <= dep_nxt;
        q_wp_r <= ~q_wp_r;
      end
      if (cmd_pop) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, acc} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stk_r[0] <= idx;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (do_pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
    if (acc) begin
      q_ctl_r[q_wp_r]   <= n_ctl;
      q_scope_r[q_wp_r] <= n_scope;
      q_par_r[q_wp_r]   <= n_par;
      q_time_r[q_wp_r]  <= in_ch.timestamp;
    end
  end

  assign cmd_valid  = (q_cnt_r != 2'd0);
  assign cmd_ctl    = q_ctl_r[q_rp_r];
  assign cmd_scope  = q_scope_r[q_rp_r];
  assign cmd_parent = q_par_r[q_rp_r];
  assign cmd_time   = q_time_r[q_rp_r];

endmodule

>>> hw/rtl/nsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_back
// Statistics table sequencer: read, subtract, update and report.
// ----------------------------------------------------------------------------
module nsp_back #(
  parameter int NUM_SCOPES = 64,
  parameter int TIME_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  nsp_pkg::cmd_ctl_t             cmd_ctl,
  input  logic [$clog2(NUM_SCOPES)-1:0] cmd_scope,
  input  logic [$clog2(NUM_SCOPES)-1:0] cmd_parent,
  input  logic [TIME_BITS-1:0]          cmd_time,
  nsp_out_if.source                     out_ch
);
  import nsp_pkg::*;

  localparam int SCOPE_W = $clog2(NUM_SCOPES);
  localparam int STAT_W  = TOTAL_W + CALLS_W + 2 * TIME_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIFF = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  cmd_ctl_t             c_ctl_r;
  logic [SCOPE_W-1:0]   c_scope_r, c_par_r;
  logic [TIME_BITS-1:0] c_time_r;
  logic                 sv_s_r, nv_s_r, nv_p_r;

  logic [NUM_SCOPES-1:0] stat_vld_r, nest_vld_r;

  logic [SCOPE_W-1:0]   raddr_s, raddr_p;
  logic [TIME_BITS-1:0] start_rd;
  logic [STAT_W-1:0]    stat_rd, stat_wd;
  logic [TOTAL_W-1:0]   nest_s_rd, nest_p_rd;

  // values captured in S_DIFF
  logic [TIME_BITS-1:0] el_r, min_r, max_r;
  logic [TOTAL_W-1:0]   tot_r, nest_s_r, nest_p_r;
  logic [CALLS_W-1:0]   calls_r;

  // update results
  logic [TOTAL_W:0]     tot_sum, nest_sum;
  logic [TOTAL_W-1:0]   tot_n, nest_n;
  logic [CALLS_W-1:0]   calls_n;
  logic [TIME_BITS-1:0] min_n, max_n;
  logic                 we_start, we_stat, we_nest, do_clear, fire;

  logic                 ov_r;
  logic [1:0]           o_status_r, o_status_nxt;
  logic [SCOPE_W+IDX_W-1:0] o_scope_ext;
  logic [IDX_W-1:0]     o_scope_r, o_scope_nxt;
  logic [TIME_BITS-1:0] o_el_r, o_min_r, o_max_r;
  logic [TIME_BITS-1:0] o_el_nxt, o_min_nxt, o_max_nxt;
  logic [TOTAL_W-1:0]   o_tot_r, o_nest_r, o_tot_nxt, o_nest_nxt;
  logic [CALLS_W-1:0]   o_calls_r, o_calls_nxt;

  assign raddr_s = (state_r == S_IDLE) ? cmd_scope  : c_scope_r;
  assign raddr_p = (state_r == S_IDLE) ? cmd_parent : c_par_r;

  nsp_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_SCOPES)) u_start (
    .clk(clk), .we(we_start), .waddr(c_scope_r), .wdata(c_time_r),
    .raddr(raddr_s), .rdata(start_rd));

  nsp_ram #(.WIDTH(STAT_W), .DEPTH(NUM_SCOPES)) u_stat (
    .clk(clk), .we(we_stat), .waddr(c_scope_r), .wdata(stat_wd),
    .raddr(raddr_s), .rdata(stat_rd));

  // nested totals are kept twice so the scope and its parent read together
  nsp_ram #(.WIDTH(TOTAL_W), .DEPTH(NUM_SCOPES)) u_nest_s (
    .clk(clk), .we(we_nest), .waddr(c_par_r), .wdata(nest_n),
    .raddr(raddr_s), .rdata(nest_s_rd));

  nsp_ram #(.WIDTH(TOTAL_W), .DEPTH(NUM_SCOPES)) u_nest_p (
    .clk(clk), .we(we_nest), .waddr(c_par_r), .wdata(nest_n),
    .raddr(raddr_p), .rdata(nest_p_rd));

  assign fire    = (state_r == S_UPD) && (!ov_r || out_ch.ready);
  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (cmd_valid) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_UPD;
      S_UPD:   if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // saturating updates
  always_comb begin
    tot_sum  = {1'b0, tot_r} + {1'b0, TOTAL_W'(el_r)};
    nest_sum = {1'b0, nest_p_r} + {1'b0, TOTAL_W'(el_r)};
    tot_n    = tot_sum[TOTAL_W]  ? '1 : tot_sum[TOTAL_W-1:0];
    nest_n   = nest_sum[TOTAL_W] ? '1 : nest_sum[TOTAL_W-1:0];
    calls_n  = (calls_r == '1) ? calls_r : calls_r + 1'b1;
    min_n    = (el_r < min_r) ? el_r : min_r;
    max_n    = (el_r > max_r) ? el_r : max_r;
    stat_wd  = {tot_n, calls_n, min_n, max_n};
    we_start = fire && (c_ctl_r.kind == K_BEGIN);
    we_stat  = fire && (c_ctl_r.kind == K_END);
    we_nest  = we_stat && c_ctl_r.has_parent;
    do_clear = fire && (c_ctl_r.kind == K_CLEAR);
  end

  // result fields for the command in S_UPD
  always_comb begin
    o_status_nxt = ST_OK;
    o_scope_nxt  = o_scope_ext[IDX_W-1:0];
    o_el_nxt     = '0;
    o_tot_nxt    = '0;
    o_calls_nxt  = '0;
    o_min_nxt    = '0;
    o_max_nxt    = '0;
    o_nest_nxt   = '0;
    case (c_ctl_r.kind)
      K_END: begin
        o_el_nxt    = el_r;
        o_tot_nxt   = tot_n;
        o_calls_nxt = calls_n;
        o_min_nxt   = min_n;
        o_max_nxt   = max_n;
        o_nest_nxt  = (c_ctl_r.has_parent && c_par_r == c_scope_r) ? nest_n : nest_s_r;
      end
      K_READ: begin
        o_tot_nxt   = tot_r;
        o_calls_nxt = calls_r;
        o_min_nxt   = min_r;
        o_max_nxt   = max_r;
        o_nest_nxt  = nest_s_r;
      end
      K_OVF:   o_status_nxt = ST_OVERFLOW;
      K_UNF: begin
        o_status_nxt = ST_UNDERFLOW;
        o_scope_nxt  = '0;
      end
      K_CLEAR: o_scope_nxt = '0;
      default: o_status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      stat_vld_r <= '0;
      nest_vld_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_clear) begin
        stat_vld_r <= '0;
        nest_vld_r <= '0;
      end
      if (we_stat) stat_vld_r[c_scope_r] <= 1'b1;
      if (we_nest) nest_vld_r[c_par_r]   <= 1'b1;
      if (fire) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      c_ctl_r   <= cmd_ctl;
      c_scope_r <= cmd_scope;
      c_par_r   <= cmd_parent;
      c_time_r  <= cmd_time;
      sv_s_r    <= stat_vld_r[cmd_scope];
      nv_s_r    <= nest_vld_r[cmd_scope];
      nv_p_r    <= nest_vld_r[cmd_parent];
    end
    if (state_r == S_DIFF) begin
      el_r     <= c_time_r - start_rd;
      tot_r    <= sv_s_r ? stat_rd[STAT_W-1 -: TOTAL_W] : '0;
      calls_r  <= sv_s_r ? stat_rd[2*TIME_BITS +: CALLS_W] : '0;
      min_r    <= sv_s_r ? stat_rd[TIME_BITS +: TIME_BITS] : '1;
      max_r    <= sv_s_r ? stat_rd[0 +: TIME_BITS] : '0;
      nest_s_r <= nv_s_r ? nest_s_rd : '0;
      nest_p_r <= nv_p_r ? nest_p_rd : '0;
    end
    if (fire) begin
      o_status_r <= o_status_nxt;
      o_scope_r  <= o_scope_nxt;
      o_el_r     <= o_el_nxt;
      o_tot_r    <= o_tot_nxt;
      o_calls_r  <= o_calls_nxt;
      o_min_r    <= o_min_nxt;
      o_max_r    <= o_max_nxt;
      o_nest_r   <= o_nest_nxt;
    end
  end

  assign o_scope_ext = {{IDX_W{1'b0}}, c_scope_r};

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.result_scope = o_scope_r;
  assign out_ch.elapsed      = o_el_r;
  assign out_ch.total_ticks  = o_tot_r;
  assign out_ch.calls        = o_calls_r;
  assign out_ch.min_ticks    = o_min_r;
  assign out_ch.max_ticks    = o_max_r;
  assign out_ch.nested_ticks = o_nest_r;

endmodule

>>> hw/rtl/nested_scope_profiler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_scope_profiler
// Hierarchical scope profiler. Requests are begin, end, read and clear, each
// with a tick timestamp; every request returns exactly one result. The front
// end keeps the scope stack and resolves overflow and underflow at once, then
// queues up to two commands. The back end owns the statistics table and runs
// a table read, an elapsed subtract and a saturating update for each request,
// taking no new request until the last has left that read-modify-write loop;
// a stalled result port holds the back end in its update step while the front
// keeps taking requests until the queue fills. Clear takes effect through
// per-scope valid bits, so there is no clearing pass after reset or clear.
// ----------------------------------------------------------------------------
`include "nested_scope_profiler_macros.svh"

module nested_scope_profiler #(
  parameter int NUM_SCOPES  = 64,
  parameter int STACK_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  nsp_in_if.sink    in_ch,
  nsp_out_if.source out_ch
);
  import nsp_pkg::*;

  localparam int SCOPE_W = $clog2(NUM_SCOPES);

  // front-to-back command queue head
  logic                 cmd_valid;
  logic                 cmd_pop;
  cmd_ctl_t             cmd_ctl;
  logic [SCOPE_W-1:0]   cmd_scope;
  logic [SCOPE_W-1:0]   cmd_parent;
  logic [TIME_BITS-1:0] cmd_time;

  nsp_front #(
    .NUM_SCOPES (NUM_SCOPES),
    .STACK_DEPTH(STACK_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_ctl   (cmd_ctl),
    .cmd_scope (cmd_scope),
    .cmd_parent(cmd_parent),
    .cmd_time  (cmd_time)
  );

  nsp_back #(
    .NUM_SCOPES(NUM_SCOPES),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_ctl   (cmd_ctl),
    .cmd_scope (cmd_scope),
    .cmd_parent(cmd_parent),
    .cmd_time  (cmd_time),
    .out_ch    (out_ch)
  );

  // back end never takes two commands in a row
  `NSP_ASSERT_NXT(a_pop_spacing, cmd_pop, !cmd_pop, "back end popped twice in a row")
  // an underflow reports nothing but its status
  `NSP_ASSERT_NOW(a_unf_clean, out_ch.valid && out_ch.status == ST_UNDERFLOW, out_ch.result_scope == '0 && out_ch.elapsed == '0 && out_ch.calls == '0, "underflow result carries data")
  // a scope with calls has min not above max
  `NSP_ASSERT_NOW(a_min_max, out_ch.valid && out_ch.calls != '0, out_ch.min_ticks <= out_ch.max_ticks, "min above max")

endmodule
